// ===== rtl/midpoint_line_rasterizer_defines.svh =====
// Assertion macros for the midpoint line rasterizer.
// Included by the RTL modules that carry concurrent checks; no dependencies.
`ifndef MIDPOINT_LINE_RASTERIZER_DEFINES_SVH
`define MIDPOINT_LINE_RASTERIZER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define MLR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define MLR_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define MLR_ASSERT(lbl, clk, rst, prop, msg)
`define MLR_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

// ===== rtl/mlr_pkg.sv =====
// Shared types and fixed field widths for the midpoint line rasterizer.
// No dependencies.
package mlr_pkg;

  localparam int COORD_W = 6;   // grid coordinate field width
  localparam int LEVEL_W = 8;   // color level field width
  localparam int IN_W    = 24;  // four coordinates, packed
  localparam int OUT_W   = 32;  // two coordinates and two levels, padded to bytes
  localparam int D_W     = 9;   // doubled midpoint decision, signed

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_ORIENT = 6'b000010,
    ST_PREP   = 6'b000100,
    ST_DIV    = 6'b001000,
    ST_CINIT  = 6'b010000,
    ST_WALK   = 6'b100000
  } state_t;

endpackage

// ===== rtl/midpoint_line_rasterizer.sv =====
// Midpoint line rasterizer top level: line command in, interior pixels out.
// Depends on mlr_pkg and midpoint_line_rasterizer_defines.svh.
//
// One transaction on the input stream carries a line with two grid endpoints;
// the block answers with one output transaction per interior pixel (both
// endpoints are left out) in walk order, tlast on the final pixel, and nothing
// at all for coincident or adjacent endpoints. Coordinates at or above
// GRID_SIZE saturate to GRID_SIZE-1. The walk always runs towards increasing
// column, so a line given right-to-left comes out starting next to its second
// endpoint. Each pixel carries blue = floor(CMAX*t/len) and red = CMAX-blue,
// CMAX = 2^COLOR_BITS-1, t the major-axis distance from the first endpoint.
// Sequence: setup steps (capture, octant classification, first midpoint
// decision), the bit-serial divider that forms CMAX/len, seeding of the color
// accumulator, then one pixel per cycle from the shared decision/color stepper
// while the output is not stalled; a line with no interior pixels ends after
// the setup. s_axis_tready is high only while no line is in progress; the
// registered output stage still lets the last pixel wait while the next line
// is taken.
module midpoint_line_rasterizer #(
  parameter int GRID_SIZE  = 64,
  parameter int COLOR_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  // {second_y, second_x, first_y, first_x}, first_x in bits 5:0
  input  logic [mlr_pkg::IN_W-1:0]   s_axis_tdata,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // {4'b0, blue_level, red_level, pixel_y, pixel_x}, pixel_x in bits 5:0
  output logic [mlr_pkg::OUT_W-1:0]  m_axis_tdata,
  output logic                       m_axis_tlast,   // last_pixel
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready
);
  import mlr_pkg::*;

`include "midpoint_line_rasterizer_defines.svh"

  localparam int CW    = COLOR_BITS;
  localparam int CNT_W = $clog2(COLOR_BITS + 1);
  localparam logic [CW-1:0]      CMAX      = {CW{1'b1}};
  localparam logic [COORD_W:0]   GRID_LIM  = (COORD_W+1)'(GRID_SIZE);
  localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(GRID_SIZE - 1);
  localparam logic [CNT_W-1:0]   DIV_LAST  = CNT_W'(COLOR_BITS - 1);

  state_t state, state_next;

  // captured endpoints (saturated)
  logic [COORD_W-1:0] x0, y0, x1, y1;
  // reduced frame
  logic               swapped, steep, neg;
  logic [COORD_W-1:0] a0, b0, da, db;
  // walk state
  logic [COORD_W-1:0] k, b;
  logic signed [D_W-1:0] d;
  // divider: quo = CMAX / da, rem = CMAX % da
  logic [CW-1:0]      quo;
  logic [COORD_W-1:0] rem;
  logic [CNT_W-1:0]   cnt;
  // color accumulator: blue = q, with remainder r of CMAX*t over da
  logic [CW-1:0]      q;
  logic [COORD_W-1:0] r;

  function automatic logic [COORD_W-1:0] sat(input logic [COORD_W-1:0] c);
    return ({1'b0, c} >= GRID_LIM) ? COORD_MAX : c;
  endfunction

  // ---------------- octant classification ----------------
  logic               swap_c, neg_c, steep_c;
  logic [COORD_W-1:0] sx0, sy0, sx1, sy1, dx_c, dy_abs;
  logic signed [COORD_W:0] dy_c;

  always_comb begin
    swap_c = (x1 < x0);
    sx0    = swap_c ? x1 : x0;
    sy0    = swap_c ? y1 : y0;
    sx1    = swap_c ? x0 : x1;
    sy1    = swap_c ? y0 : y1;
    dx_c   = sx1 - sx0;
    dy_c   = $signed({1'b0, sy1}) - $signed({1'b0, sy0});
    neg_c  = dy_c[COORD_W];
    dy_abs = neg_c ? COORD_W'(-dy_c) : COORD_W'(dy_c);
    steep_c = (dy_abs > dx_c);
  end

  // ---------------- shared midpoint decision step ----------------
  // PREP feeds the initial decision da-2db, WALK feeds the running one.
  logic signed [D_W-1:0] d_init, d_src, d_step;
  logic                  minor_step;

  always_comb begin
    d_init = $signed({3'b000, da}) - $signed({2'b00, db, 1'b0});
    d_src  = (state == ST_PREP) ? d_init : d;
    minor_step = d_src[D_W-1];
    if (minor_step) begin
      d_step = d_src + $signed({2'b00, da - db, 1'b0});
    end else begin
      d_step = d_src - $signed({2'b00, db, 1'b0});
    end
  end

  // ---------------- bit-serial divider step ----------------
  // Dividend is all ones, so every shifted-in bit is 1.
  logic [COORD_W:0] rem_sh;
  logic             rem_ge;

  always_comb begin
    rem_sh = {rem, 1'b1};
    rem_ge = (rem_sh >= {1'b0, da});
  end

  // ---------------- color step ----------------
  logic [COORD_W:0]        up_sum;
  logic                    up_wrap;
  logic signed [COORD_W+1:0] dn_dif;
  logic                    dn_wrap;
  logic [CW-1:0]           q_next;
  logic [COORD_W-1:0]      r_next;

  always_comb begin
    up_sum  = {1'b0, r} + {1'b0, rem};
    up_wrap = (up_sum >= {1'b0, da});
    dn_dif  = $signed({2'b00, r}) - $signed({2'b00, rem});
    dn_wrap = dn_dif[COORD_W+1];
    if (swapped) begin
      q_next = q - quo - CW'(dn_wrap);
      r_next = dn_wrap ? COORD_W'(dn_dif + $signed({2'b00, da})) : COORD_W'(dn_dif);
    end else begin
      q_next = q + quo + CW'(up_wrap);
      r_next = up_wrap ? COORD_W'(up_sum - {1'b0, da}) : COORD_W'(up_sum);
    end
  end

  // ---------------- pixel position ----------------
  logic [COORD_W-1:0] a_cur, minor_pos, px, py;
  logic               out_free, emit, last_k;

  always_comb begin
    a_cur     = a0 + k;
    minor_pos = b;
    px        = steep ? b : a_cur;
    py        = steep ? a_cur : minor_pos;
    if (neg) begin
      if (steep) begin
        py = (a0 << 1) - a_cur;
      end else begin
        py = (b0 << 1) - b;
      end
    end
    out_free = !m_axis_tvalid || m_axis_tready;
    emit     = (state == ST_WALK) && out_free;
    last_k   = (k == da - COORD_W'(1));
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (s_axis_tvalid) state_next = ST_ORIENT;
      ST_ORIENT: state_next = ST_PREP;
      ST_PREP:   state_next = (da > COORD_W'(1)) ? ST_DIV : ST_IDLE;
      ST_DIV:    if (cnt == DIV_LAST) state_next = ST_CINIT;
      ST_CINIT:  state_next = ST_WALK;
      ST_WALK:   if (emit && last_k) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        x0 <= sat(s_axis_tdata[5:0]);
        y0 <= sat(s_axis_tdata[11:6]);
        x1 <= sat(s_axis_tdata[17:12]);
        y1 <= sat(s_axis_tdata[23:18]);
      end
      ST_ORIENT: begin
        swapped <= swap_c;
        neg     <= neg_c;
        steep   <= steep_c;
        a0      <= steep_c ? sy0 : sx0;
        b0      <= steep_c ? sx0 : sy0;
        da      <= steep_c ? dy_abs : dx_c;
        db      <= steep_c ? dx_c : dy_abs;
      end
      ST_PREP: begin
        // decision for k = 0 applied here; the walk starts at k = 1
        d   <= d_step;
        b   <= b0 + COORD_W'(minor_step);
        k   <= COORD_W'(1);
        rem <= '0;
        quo <= '0;
        cnt <= '0;
      end
      ST_DIV: begin
        rem <= rem_ge ? COORD_W'(rem_sh - {1'b0, da}) : COORD_W'(rem_sh);
        quo <= (quo << 1) | CW'(rem_ge);
        cnt <= cnt + CNT_W'(1);
      end
      ST_CINIT: begin
        // t = 1 forward, t = len-1 for a swapped line
        if (swapped) begin
          q <= CMAX - quo - CW'(rem != '0);
          r <= (rem != '0) ? da - rem : '0;
        end else begin
          q <= quo;
          r <= rem;
        end
      end
      ST_WALK: begin
        if (emit) begin
          d <= d_step;
          b <= b + COORD_W'(minor_step);
          k <= k + COORD_W'(1);
          q <= q_next;
          r <= r_next;
        end
      end
      default: ;
    endcase
  end

  // output stage
  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= {4'b0000, LEVEL_W'(q), LEVEL_W'(CMAX - q), py, px};
      m_axis_tlast <= last_k;
    end
  end

  // ---------------- checks ----------------
  `MLR_ASSERT(a_walk_k_range, clk, rst, (state == ST_WALK) |-> (k < da), "walk index past line length")
  `MLR_ASSERT(a_walk_rem, clk, rst, (state == ST_WALK) |-> (r < da), "color remainder not below length")
  `MLR_ASSERT(a_accept_start, clk, rst, (s_axis_tvalid && s_axis_tready) |=> (state == ST_ORIENT), "accepted line did not start")
  `MLR_NEVER(a_div_len, clk, rst, (state == ST_DIV) && (da < COORD_W'(2)), "divider run on short line")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for midpoint_line_rasterizer: sends line commands, predicts
// each line's interior pixels and checks every output transaction in order.
// Depends on mlr_pkg and the midpoint_line_rasterizer RTL.
module tb_top;

  localparam int GRID        = 64;
  localparam int CBITS       = 8;
  localparam int unsigned CMAX = (1 << CBITS) - 1;
  // worst case for one line: setup + divider + color seed + 62 pixels, with margin
  localparam int TAIL_CYCLES = CBITS + 80;
  // generous: ~160 lines x (62 pixels with stalls + gaps + setup)
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_REPORTS = 50;

  localparam int CW    = mlr_pkg::COORD_W;
  localparam int LW    = mlr_pkg::LEVEL_W;
  localparam int PY_LO = CW;
  localparam int RD_LO = 2 * CW;
  localparam int BL_LO = 2 * CW + LW;

  typedef logic [CW-1:0] coord_t;

  // one predicted pixel, in output field order
  typedef struct packed {
    coord_t        px;
    coord_t        py;
    logic [LW-1:0] red;
    logic [LW-1:0] blue;
    logic          last;
  } pixel_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  // {second_y, second_x, first_y, first_x}, first_x in bits 5:0
  logic [mlr_pkg::IN_W-1:0]  s_axis_tdata = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  // {4'b0, blue_level, red_level, pixel_y, pixel_x}, pixel_x in bits 5:0
  logic [mlr_pkg::OUT_W-1:0] m_axis_tdata;
  logic                      m_axis_tlast;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;

  pixel_t pending_pixels[$];   // predicted pixels not yet seen on the output
  pixel_t want_pix;
  int     mismatch_count = 0;
  int     pixels_seen    = 0;
  int     stall_left     = 0;
  int     cycle_count    = 0;
  bit     idle_on        = 1'b1;  // random gaps on both streams while set

  midpoint_line_rasterizer #(
    .GRID_SIZE  (GRID),
    .COLOR_BITS (CBITS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // timeout: a hung block or a missing pixel ends up here
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL midpoint_line_rasterizer");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < MAX_REPORTS)
      $display("ERROR pixel %0d %s: got %0d, expected %0d", pixels_seen, what, got, want);
    mismatch_count++;
  endtask

  // coordinates at or above the grid size saturate to the last cell
  function automatic int sat_coord(input coord_t c);
    return (int'(c) >= GRID) ? GRID - 1 : int'(c);
  endfunction

  // Midpoint walk in a reduced frame (walk towards increasing column, steep lines
  // with axes swapped, negative slope mirrored about the start row). Queues every
  // pixel strictly between the endpoints, in walk order.
  function automatic void plot_interior(input coord_t fx, fy, sx, sy);
    int x0, y0, x1, y1, tmp, dx, dy, a0, b0, da, db, d, b, a, k;
    int unsigned t, blue;
    bit swapped, steep, neg;
    pixel_t pix;
    x0 = sat_coord(fx);
    y0 = sat_coord(fy);
    x1 = sat_coord(sx);
    y1 = sat_coord(sy);
    swapped = (x1 < x0);
    if (swapped) begin
      tmp = x0; x0 = x1; x1 = tmp;
      tmp = y0; y0 = y1; y1 = tmp;
    end
    dx  = x1 - x0;
    dy  = y1 - y0;
    neg = (dy < 0);
    if (neg) dy = -dy;
    steep = (dy > dx);
    if (steep) begin
      a0 = y0; b0 = x0; da = dy; db = dx;
    end else begin
      a0 = x0; b0 = y0; da = dx; db = dy;
    end
    d = da - 2 * db;
    b = b0;
    for (k = 0; k < da; k++) begin
      if (k > 0) begin
        a = a0 + k;
        // color distance is measured from the first (red) endpoint
        t = swapped ? unsigned'(da - k) : unsigned'(k);
        blue = (CMAX * t) / unsigned'(da);
        case ({steep, neg})
          2'b00: begin
            pix.px = coord_t'(a); pix.py = coord_t'(b);
          end
          2'b10: begin
            pix.px = coord_t'(b); pix.py = coord_t'(a);
          end
          2'b01: begin
            pix.px = coord_t'(a); pix.py = coord_t'(2 * b0 - b);
          end
          default: begin
            pix.px = coord_t'(b); pix.py = coord_t'(2 * a0 - a);
          end
        endcase
        pix.red  = LW'(CMAX - blue);
        pix.blue = LW'(blue);
        pix.last = (k == da - 1);
        pending_pixels.push_back(pix);
      end
      // a tie (d == 0) keeps the minor coordinate
      if (d < 0) begin
        b++;
        d += 2 * (da - db);
      end else begin
        d -= 2 * db;
      end
    end
  endfunction

  // One line command; predictions are queued once the transaction is accepted.
  task automatic send_line(input coord_t fx, fy, sx, sy);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_axis_tdata  <= {sy, sx, fy, fx};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    plot_interior(fx, fy, sx, sy);
  endtask

  // Output side: check each accepted pixel against the oldest prediction, then
  // decide tready for the next cycle, with random stall bursts.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected pixel, tdata", int'(m_axis_tdata), 0);
      end else begin
        want_pix = pending_pixels.pop_front();
        if (m_axis_tdata[CW-1:0] !== want_pix.px)
          report_mismatch("pixel_x", int'(m_axis_tdata[CW-1:0]), int'(want_pix.px));
        if (m_axis_tdata[PY_LO +: CW] !== want_pix.py)
          report_mismatch("pixel_y", int'(m_axis_tdata[PY_LO +: CW]), int'(want_pix.py));
        if (m_axis_tdata[RD_LO +: LW] !== want_pix.red)
          report_mismatch("red_level", int'(m_axis_tdata[RD_LO +: LW]), int'(want_pix.red));
        if (m_axis_tdata[BL_LO +: LW] !== want_pix.blue)
          report_mismatch("blue_level", int'(m_axis_tdata[BL_LO +: LW]),
                          int'(want_pix.blue));
        if (m_axis_tlast !== want_pix.last)
          report_mismatch("last_pixel", int'(m_axis_tlast), int'(want_pix.last));
      end
      pixels_seen++;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 13);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // coincident and adjacent endpoints: no pixel at all
  task automatic test_degenerate_lines();
    send_line(10, 10, 10, 10);
    send_line(0, 0, 0, 0);
    send_line(5, 5, 6, 6);
    send_line(5, 5, 5, 4);
    send_line(63, 63, 62, 63);
  endtask

  // every octant from the middle of the grid, axis-aligned lines and ties
  task automatic test_octants();
    send_line(32, 32, 50, 40);
    send_line(32, 32, 40, 50);
    send_line(32, 32, 24, 50);
    send_line(32, 32, 14, 40);
    send_line(32, 32, 14, 24);
    send_line(32, 32, 24, 14);
    send_line(32, 32, 40, 14);
    send_line(32, 32, 50, 24);
    send_line(32, 32, 60, 32);   // horizontal, rightwards
    send_line(60, 32, 3, 32);    // horizontal, leftwards
    send_line(32, 32, 32, 60);   // vertical, upwards
    send_line(32, 60, 32, 5);    // vertical, downwards
    send_line(10, 10, 20, 20);   // diagonal
    send_line(0, 0, 10, 5);      // slope one half: decision starts at a tie
  endtask

  // full-grid lines between corners and edges
  task automatic test_extremes();
    send_line(0, 0, 63, 63);
    send_line(63, 0, 0, 63);
    send_line(0, 63, 63, 0);
    send_line(63, 63, 0, 0);
    send_line(0, 0, 63, 0);
    send_line(0, 0, 0, 63);
  endtask

  // random lines; four in ten are anywhere on the grid, the rest short or special shapes
  task automatic test_random_lines(input int count);
    coord_t fx, fy, sx, sy;
    int len;
    repeat (count) begin
      fx = coord_t'($urandom);
      fy = coord_t'($urandom);
      sx = coord_t'($urandom);
      sy = coord_t'($urandom);
      len = $urandom_range(2, 40);
      case ($urandom_range(0, 9))
        0, 1: begin  // short, possibly degenerate
          sx = coord_t'(fx + $urandom_range(0, 6) - 3);
          sy = coord_t'(fy + $urandom_range(0, 6) - 3);
        end
        2: sy = fy;  // horizontal
        3: sx = fx;  // vertical
        4: begin     // diagonal, either slope sign
          sx = coord_t'(fx + len);
          sy = $urandom_range(0, 1) ? coord_t'(fy + len) : coord_t'(fy - len);
        end
        5: begin     // both ends on the border
          fx = $urandom_range(0, 1) ? coord_t'(0) : coord_t'(GRID - 1);
          sy = $urandom_range(0, 1) ? coord_t'(0) : coord_t'(GRID - 1);
        end
        default: ;
      endcase
      send_line(fx, fy, sx, sy);
    end
  endtask

  // closing stretch: back-to-back transactions, output never stalls
  task automatic test_steady_stream();
    idle_on = 1'b0;
    test_random_lines(30);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_degenerate_lines();
    test_octants();
    test_extremes();
    test_random_lines(105);
    test_steady_stream();
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    // catch any stray pixel after the last expected one
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS midpoint_line_rasterizer");
    end else begin
      $display("FAIL midpoint_line_rasterizer");
    end
    $finish;
  end

endmodule
